FILE: rtl/core/clac_pkg.sv
`timescale 1ns / 1ps

package clac_pkg;

  typedef enum logic [2:0] {
    MODE_UNLOCK    = 3'd0,
    MODE_LOCK      = 3'd1,
    MODE_ERROR     = 3'd2,
    MODE_RUNNING   = 3'd3,
    MODE_UNLOCKING = 3'd4,
    MODE_LOCKING   = 3'd5
  } lock_mode_e;

  typedef enum logic [2:0] {
    CFG_CURRENT_LIMIT = 3'd0,
    CFG_SPEED_LIMIT   = 3'd1,
    CFG_RUN_TICKS     = 3'd2,
    CFG_OWN_NODE      = 3'd3,
    CFG_MASTER_NODE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACK_NONE = 3'd0,
    ACK_RESP = 3'd4,
    ACK_HAVE = 3'd5
  } ack_e;

  typedef enum logic [1:0] {
    LVL_CTRL   = 2'd1,
    LVL_UPDATE = 2'd3
  } level_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [7:0] HDR_CTRL    = 8'h80;
  localparam logic [7:0] HDR_QUERY   = 8'h81;
  localparam logic [7:0] CMD_UNLOCK  = 8'hC9;
  localparam logic [7:0] CMD_LOCK    = 8'hCA;
  localparam logic [7:0] CMD_STATUS  = 8'hC0;
  localparam logic [7:0] CMD_VERSION = 8'h01;

  localparam logic [55:0] TAIL_MODE_NORMAL = 56'h02_0000;
  localparam logic [55:0] TAIL_MODE_UPDATE = 56'h01_0000;
  localparam logic [63:0] VERSION_REPLY    = 64'h0200_0101;

  localparam logic [7:0] FLAG_RPM   = 8'h02;
  localparam logic [7:0] FLAG_MOTOR = 8'h04;

  localparam logic [3:0] LEN_SHORT = 4'd6;
  localparam logic [3:0] LEN_FULL  = 4'd8;

  localparam logic [11:0] CURRENT_LIMIT_RST = 12'd24;
  localparam logic [7:0]  SPEED_LIMIT_RST   = 8'd15;
  localparam logic [7:0]  RUN_TICKS_RST     = 8'd20;
  localparam logic [5:0]  OWN_NODE_RST      = 6'd9;
  localparam logic [5:0]  MASTER_NODE_RST   = 6'd1;

  typedef struct packed {
    logic        func;
    logic [28:0] frame_id;
    logic [63:0] payload;
    logic [11:0] adc_sample;
    logic        lock_switch;
    logic [7:0]  axle_rpm;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [28:0] tx_id;
    logic [3:0]  tx_len;
    logic [63:0] tx_payload;
    logic        motor_a;
    logic        motor_b;
    logic        reset_request;
    logic [2:0]  lock_status;
  } out_item_t;

  typedef struct packed {
    logic [11:0] current_limit;
    logic [7:0]  speed_limit;
    logic [7:0]  run_ticks;
    logic [5:0]  own_node;
    logic [5:0]  master_node;
  } cfg_t;

  typedef struct packed {
    lock_mode_e  mode;
    logic [7:0]  err_flags;
    logic [7:0]  tick;
    logic        timer_on;
    logic        drive_a;
    logic        drive_b;
  } state_t;

  function automatic logic [63:0] report(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] flags);
    report = {32'h0, flags, b2, b1, b0};
  endfunction

  function automatic logic [7:0] status_byte(input lock_mode_e mode);
    case (mode)
      MODE_LOCK:   status_byte = 8'h00;
      MODE_UNLOCK: status_byte = 8'h01;
      default:     status_byte = 8'h02;
    endcase
  endfunction

endpackage

FILE: rtl/core/clac_cfg_regs.sv
`timescale 1ns / 1ps

module clac_cfg_regs
  import clac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CURRENT_LIMIT: cfg_d.current_limit = cfg_data_i;
        CFG_SPEED_LIMIT:   cfg_d.speed_limit   = cfg_data_i[7:0];
        CFG_RUN_TICKS:     cfg_d.run_ticks     = cfg_data_i[7:0];
        CFG_OWN_NODE:      cfg_d.own_node      = cfg_data_i[5:0];
        CFG_MASTER_NODE:   cfg_d.master_node   = cfg_data_i[5:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit <= CURRENT_LIMIT_RST;
      cfg_q.speed_limit   <= SPEED_LIMIT_RST;
      cfg_q.run_ticks     <= RUN_TICKS_RST;
      cfg_q.own_node      <= OWN_NODE_RST;
      cfg_q.master_node   <= MASTER_NODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/clac_step.sv
`timescale 1ns / 1ps

module clac_step
  import clac_pkg::*;
(
  input  in_item_t  item_i,
  input  state_t    st_i,
  input  cfg_t      cfg_i,
  output state_t    st_o,
  output out_item_t res_o
);

  logic [2:0]  ack;
  logic [5:0]  dest;
  logic [5:0]  src;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [55:0] tail;
  logic        mine;
  logic [7:0]  tick_inc;
  logic        over;
  logic        unl;
  logic        snd;
  logic [1:0]  lvl;
  logic [2:0]  tx_ack;
  logic [63:0] bytes;
  logic        len8;
  logic        rst_req;
  logic [7:0]  b2;
  state_t      st_d;

  assign ack      = item_i.frame_id[19:17];
  assign dest     = item_i.frame_id[11:6];
  assign src      = item_i.frame_id[5:0];
  assign b0       = item_i.payload[7:0];
  assign b1       = item_i.payload[15:8];
  assign tail     = item_i.payload[63:8];
  assign mine     = (src == cfg_i.master_node) && (dest == cfg_i.own_node);
  assign tick_inc = st_i.tick + 8'd1;
  assign over     = item_i.adc_sample > cfg_i.current_limit;
  assign unl      = (st_i.mode == MODE_UNLOCKING);

  always_comb begin
    st_d    = st_i;
    snd     = 1'b0;
    lvl     = LVL_CTRL;
    tx_ack  = ACK_NONE;
    bytes   = '0;
    len8    = 1'b0;
    rst_req = 1'b0;
    b2      = 8'h00;
    if (!item_i.func) begin
      if (mine && ack == ACK_HAVE) begin
        if (b0 == HDR_CTRL && b1 == CMD_UNLOCK) begin
          if (st_i.mode == MODE_UNLOCK) begin
            snd   = 1'b1;
            bytes = report(8'h00, CMD_UNLOCK, 8'h00, st_i.err_flags);
          end else begin
            st_d.drive_a  = 1'b1;
            st_d.drive_b  = 1'b0;
            st_d.mode     = MODE_UNLOCKING;
            st_d.timer_on = 1'b1;
          end
        end else if (b0 == HDR_CTRL && b1 == CMD_LOCK) begin
          if (item_i.axle_rpm > cfg_i.speed_limit) begin
            st_d.err_flags = st_i.err_flags | FLAG_RPM;
            snd   = 1'b1;
            bytes = report(8'h00, CMD_LOCK, status_byte(st_i.mode), st_d.err_flags);
          end else if (st_i.mode == MODE_LOCK) begin
            snd   = 1'b1;
            bytes = report(8'h00, CMD_LOCK, 8'h00, st_i.err_flags);
          end else begin
            st_d.drive_a  = 1'b0;
            st_d.drive_b  = 1'b1;
            st_d.mode     = MODE_LOCKING;
            st_d.timer_on = 1'b1;
          end
        end else if (b0 == HDR_QUERY && b1 == CMD_STATUS) begin
          snd   = 1'b1;
          bytes = report(8'h01, CMD_STATUS, status_byte(st_i.mode), st_i.err_flags);
        end else if (b0 == HDR_QUERY && tail == TAIL_MODE_NORMAL) begin
          snd    = 1'b1;
          lvl    = LVL_UPDATE;
          tx_ack = ACK_RESP;
          bytes  = item_i.payload;
          len8   = 1'b1;
        end else if (b0 == HDR_QUERY && tail == TAIL_MODE_UPDATE) begin
          snd     = 1'b1;
          lvl     = LVL_UPDATE;
          tx_ack  = ACK_RESP;
          bytes   = item_i.payload;
          len8    = 1'b1;
          rst_req = 1'b1;
        end
      end else if (mine && ack == ACK_NONE) begin
        if (b0 == HDR_QUERY && b1 == CMD_VERSION) begin
          snd   = 1'b1;
          lvl   = LVL_UPDATE;
          bytes = VERSION_REPLY;
          len8  = 1'b1;
        end
      end
    end else if (st_i.timer_on) begin
      st_d.tick = tick_inc;
      if (tick_inc == cfg_i.run_ticks) begin
        st_d.timer_on = 1'b0;
        st_d.drive_a  = 1'b0;
        st_d.drive_b  = 1'b0;
        st_d.tick     = '0;
        if (st_i.mode == MODE_UNLOCKING || st_i.mode == MODE_LOCKING) begin
          if (over) begin
            st_d.mode      = MODE_ERROR;
            st_d.err_flags = st_i.err_flags | FLAG_MOTOR;
          end else begin
            st_d.err_flags = st_i.err_flags & ~FLAG_MOTOR;
          end
          if (unl) begin
            if (!item_i.lock_switch) begin
              b2        = 8'h01;
              st_d.mode = MODE_UNLOCK;
            end else begin
              st_d.mode = MODE_LOCK;
            end
          end else if (item_i.lock_switch) begin
            st_d.mode = MODE_LOCK;
          end else begin
            b2 = 8'h02;
          end
          snd   = 1'b1;
          bytes = report(8'h00, unl ? CMD_UNLOCK : CMD_LOCK, b2, st_d.err_flags);
        end
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (snd) begin
      res_o.tx_valid   = 1'b1;
      res_o.tx_id      = {1'b0, lvl, 1'b1, 5'd0, tx_ack, 5'd0,
                          cfg_i.master_node, cfg_i.own_node};
      res_o.tx_len     = len8 ? LEN_FULL : LEN_SHORT;
      res_o.tx_payload = len8 ? bytes : {16'h0, bytes[47:0]};
    end
    res_o.motor_a       = st_d.drive_a;
    res_o.motor_b       = st_d.drive_b;
    res_o.reset_request = rst_req;
    res_o.lock_status   = st_d.mode;
  end

  assign st_o = st_d;

endmodule

FILE: rtl/core/can_lock_actuator_controller_top.sv
`timescale 1ns / 1ps
// An input beat goes through the input register and the result register to the output.
// Throughput: one item per cycle while out_ready_i is high; a stalled result beat is held.
// Decode, state update and frame build are done in one pass between the two registers.
// Reset: async active low; lock state unlocked, flags, tick count and motor drive cleared,
// configuration registers back to their defaults.

module can_lock_actuator_controller_top
  import clac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_vld_q, item_vld_d;
  out_item_t res_d, res_q;
  logic      res_vld_q, res_vld_d;
  state_t    st_q, st_d;
  logic      adv;

  clac_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  clac_step u_step (
    .item_i (item_q),
    .st_i   (st_q),
    .cfg_i  (cfg),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv        = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || adv;
  assign item_vld_d = in_ready_o ? in_valid_i : item_vld_q;
  assign res_vld_d  = adv ? 1'b1 : (res_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      st_q       <= '{mode: MODE_UNLOCK, err_flags: 8'h00, tick: 8'h00,
                      timer_on: 1'b0, drive_a: 1'b0, drive_b: 1'b0};
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_drive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.drive_a && st_q.drive_b))
    else $error("both motor lines driven");

  a_timer_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.timer_on |-> ((st_q.mode == MODE_UNLOCKING || st_q.mode == MODE_LOCKING) &&
                       (st_q.drive_a != st_q.drive_b)))
    else $error("timer running without a motor run");

  a_timer_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.timer_on |-> (!st_q.drive_a && !st_q.drive_b))
    else $error("motor driven with timer stopped");

  a_tx_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.tx_valid) |-> (res_q.tx_len == LEN_SHORT || res_q.tx_len == LEN_FULL))
    else $error("bad frame length");

  a_rst_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.reset_request) |-> (res_q.tx_valid && res_q.tx_len == LEN_FULL))
    else $error("reset request without mode echo");

endmodule

FILE: dv/can_lock_actuator_controller_top_tb.sv
`timescale 1ns / 1ps

module can_lock_actuator_controller_top_tb;
  import clac_pkg::*;

  localparam int unsigned WatchdogCycles = 400000;

  class lock_scoreboard;
    cfg_t       regs;
    lock_mode_e mode;
    logic [7:0] flags;
    logic [7:0] ticks;
    bit         timer_on;
    bit         drv_a;
    bit         drv_b;
    out_item_t  awaited[$];
    int         failures;
    int         checked;
    int         frames;
    int         runs_done;
    int         beats_in;

    function new();
      regs = {CURRENT_LIMIT_RST, SPEED_LIMIT_RST, RUN_TICKS_RST, OWN_NODE_RST,
              MASTER_NODE_RST};
      mode      = MODE_UNLOCK;
      flags     = '0;
      ticks     = '0;
      timer_on  = 1'b0;
      drv_a     = 1'b0;
      drv_b     = 1'b0;
      failures  = 0;
      checked   = 0;
      frames    = 0;
      runs_done = 0;
      beats_in  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_CURRENT_LIMIT: regs.current_limit = val;
        CFG_SPEED_LIMIT:   regs.speed_limit   = val[7:0];
        CFG_RUN_TICKS:     regs.run_ticks     = val[7:0];
        CFG_OWN_NODE:      regs.own_node      = val[5:0];
        CFG_MASTER_NODE:   regs.master_node   = val[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [7:0] mode_code();
      case (mode)
        MODE_LOCK:   return 8'h00;
        MODE_UNLOCK: return 8'h01;
        default:     return 8'h02;
      endcase
    endfunction

    function logic [63:0] status_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      return {32'h0, flags, b2, b1, b0};
    endfunction

    function out_item_t framed(level_e lvl, ack_e ack, logic [63:0] bytes, logic [3:0] len);
      out_item_t o;
      o = '0;
      o.tx_valid       = 1'b1;
      o.tx_id[27:26]   = lvl;
      o.tx_id[25]      = 1'b1;
      o.tx_id[19:17]   = ack;
      o.tx_id[11:6]    = regs.master_node;
      o.tx_id[5:0]     = regs.own_node;
      o.tx_len         = len;
      o.tx_payload     = (len >= LEN_FULL) ? bytes : {16'h0, bytes[47:0]};
      return o;
    endfunction

    function void run_motor(bit unlocking);
      drv_a    = unlocking;
      drv_b    = !unlocking;
      mode     = unlocking ? MODE_UNLOCKING : MODE_LOCKING;
      timer_on = 1'b1;
    endfunction

    function out_item_t step_actuator(in_item_t it);
      out_item_t   o;
      logic [2:0]  ack;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [55:0] tail;
      bit          mine;
      bit          over;
      bit          unl;
      bit          rst_req;
      o       = '0;
      rst_req = 1'b0;
      if (!it.func) begin
        ack  = it.frame_id[19:17];
        b0   = it.payload[7:0];
        b1   = it.payload[15:8];
        tail = it.payload[63:8];
        mine = (it.frame_id[5:0] == regs.master_node) && (it.frame_id[11:6] == regs.own_node);
        if (mine && ack == ACK_HAVE) begin
          if (b0 == HDR_CTRL && b1 == CMD_UNLOCK) begin
            if (mode == MODE_UNLOCK) begin
              o = framed(LVL_CTRL, ACK_NONE, status_bytes(8'h00, CMD_UNLOCK, 8'h00), LEN_SHORT);
            end else begin
              run_motor(1'b1);
            end
          end else if (b0 == HDR_CTRL && b1 == CMD_LOCK) begin
            if (it.axle_rpm > regs.speed_limit) begin
              b2    = mode_code();
              flags = flags | FLAG_RPM;
              o = framed(LVL_CTRL, ACK_NONE, status_bytes(8'h00, CMD_LOCK, b2), LEN_SHORT);
            end else if (mode == MODE_LOCK) begin
              o = framed(LVL_CTRL, ACK_NONE, status_bytes(8'h00, CMD_LOCK, 8'h00), LEN_SHORT);
            end else begin
              run_motor(1'b0);
            end
          end else if (b0 == HDR_QUERY && b1 == CMD_STATUS) begin
            o = framed(LVL_CTRL, ACK_NONE, status_bytes(8'h01, CMD_STATUS, mode_code()),
                       LEN_SHORT);
          end else if (b0 == HDR_QUERY && tail == TAIL_MODE_NORMAL) begin
            o = framed(LVL_UPDATE, ACK_RESP, it.payload, LEN_FULL);
          end else if (b0 == HDR_QUERY && tail == TAIL_MODE_UPDATE) begin
            o = framed(LVL_UPDATE, ACK_RESP, it.payload, LEN_FULL);
            rst_req = 1'b1;
          end
        end else if (mine && ack == ACK_NONE) begin
          if (b0 == HDR_QUERY && b1 == CMD_VERSION) begin
            o = framed(LVL_UPDATE, ACK_NONE, VERSION_REPLY, LEN_FULL);
          end
        end
      end else if (timer_on) begin
        ticks = ticks + 8'd1;
        if (ticks == regs.run_ticks) begin
          over     = it.adc_sample > regs.current_limit;
          timer_on = 1'b0;
          drv_a    = 1'b0;
          drv_b    = 1'b0;
          if (mode == MODE_UNLOCKING || mode == MODE_LOCKING) begin
            unl = (mode == MODE_UNLOCKING);
            runs_done++;
            if (over) begin
              mode  = MODE_ERROR;
              flags = flags | FLAG_MOTOR;
            end else begin
              flags = flags & ~FLAG_MOTOR;
            end
            if (unl) begin
              if (!it.lock_switch) begin
                b2   = 8'h01;
                mode = MODE_UNLOCK;
              end else begin
                b2   = 8'h00;
                mode = MODE_LOCK;
              end
            end else if (it.lock_switch) begin
              b2   = 8'h00;
              mode = MODE_LOCK;
            end else begin
              b2 = 8'h02;
            end
            o = framed(LVL_CTRL, ACK_NONE,
                       status_bytes(8'h00, unl ? CMD_UNLOCK : CMD_LOCK, b2), LEN_SHORT);
          end
          ticks = '0;
        end
      end
      o.motor_a       = drv_a;
      o.motor_b       = drv_b;
      o.reset_request = rst_req;
      o.lock_status   = mode;
      return o;
    endfunction

    function void note_beat(in_item_t it);
      out_item_t o;
      o = step_actuator(it);
      beats_in++;
      if (o.tx_valid) frames++;
      awaited.push_back(o);
    endfunction

    function void note_failure(string why, out_item_t want, out_item_t got);
      failures++;
      if (failures <= 10) begin
        $display("MISMATCH (%s) at %0t", why, $realtime);
        $display("  exp: v=%0b id=%h len=%0d pl=%h a=%0b b=%0b rr=%0b st=%0d",
                 want.tx_valid, want.tx_id, want.tx_len, want.tx_payload, want.motor_a,
                 want.motor_b, want.reset_request, want.lock_status);
        $display("  got: v=%0b id=%h len=%0d pl=%h a=%0b b=%0b rr=%0b st=%0d",
                 got.tx_valid, got.tx_id, got.tx_len, got.tx_payload, got.motor_a,
                 got.motor_b, got.reset_request, got.lock_status);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        note_failure("result with nothing pending", '0, got);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.tx_valid !== want.tx_valid || got.tx_id !== want.tx_id ||
          got.tx_len !== want.tx_len || got.tx_payload !== want.tx_payload ||
          got.motor_a !== want.motor_a || got.motor_b !== want.motor_b ||
          got.reset_request !== want.reset_request ||
          got.lock_status !== want.lock_status) begin
        note_failure("field differs", want, got);
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  lock_scoreboard sb;
  bit             calm       = 1'b0;
  int             idle_pct   = 25;
  int             ready_hold = 0;
  int             settings   = 0;

  can_lock_actuator_controller_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold = $urandom_range(0, 10);
    end else begin
      out_ready_i <= 1'b1;
      ready_hold = $urandom_range(0, 20);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_data_o);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < WatchdogCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still pending", cycles, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic drive_item(in_item_t it);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(it);
  endtask

  task automatic end_phase();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(cfg_t c);
    logic [CfgDataW-1:0] vals[5];
    vals[0] = c.current_limit;
    vals[1] = {4'h0, c.speed_limit};
    vals[2] = {4'h0, c.run_ticks};
    vals[3] = {6'h0, c.own_node};
    vals[4] = {6'h0, c.master_node};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic in_item_t addressed(logic [2:0] ack, logic [63:0] pl, logic [7:0] speed);
    in_item_t it;
    it = '0;
    it.frame_id[19:17] = ack;
    it.frame_id[11:6]  = sb.regs.own_node;
    it.frame_id[5:0]   = sb.regs.master_node;
    it.payload         = pl;
    it.axle_rpm        = speed;
    return it;
  endfunction

  function automatic in_item_t tick_in(logic [11:0] adc, logic sw);
    in_item_t it;
    it = '0;
    it.func        = 1'b1;
    it.adc_sample  = adc;
    it.lock_switch = sw;
    return it;
  endfunction

  function automatic int near_limit(int lim, int maxv);
    int v;
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, maxv);
    v = lim + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic in_item_t make_traffic(int tick_pct);
    in_item_t    it;
    logic [31:0] r;
    int          pick;
    r              = $urandom;
    it.frame_id    = r[28:0];
    it.payload     = {$urandom, $urandom};
    it.adc_sample  = 12'(near_limit(sb.regs.current_limit, 4095));
    it.lock_switch = 1'($urandom_range(0, 1));
    it.axle_rpm    = 8'(near_limit(sb.regs.speed_limit, 255));
    it.func        = 1'b0;
    pick           = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      it.func = 1'b1;
    end else if (pick < tick_pct + (100 - tick_pct) * 85 / 100) begin
      it.frame_id[19:17] = ACK_HAVE;
      it.frame_id[11:6]  = sb.regs.own_node;
      it.frame_id[5:0]   = sb.regs.master_node;
      case ($urandom_range(0, 9))
        0, 1, 2: it.payload[15:0] = {CMD_UNLOCK, HDR_CTRL};
        3, 4, 5: it.payload[15:0] = {CMD_LOCK, HDR_CTRL};
        6:       it.payload[15:0] = {CMD_STATUS, HDR_QUERY};
        7:       it.payload = {TAIL_MODE_NORMAL, HDR_QUERY};
        8:       it.payload = {TAIL_MODE_UPDATE, HDR_QUERY};
        default: begin
          it.frame_id[19:17] = ACK_NONE;
          it.payload[15:0]   = {CMD_VERSION, HDR_QUERY};
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: it.func = 1'($urandom_range(0, 1));
        1: begin
          it.frame_id[11:6] = sb.regs.own_node;
          it.frame_id[5:0]  = sb.regs.master_node;
          it.payload[15:0]  = {CMD_LOCK, HDR_CTRL};
        end
        2: begin
          it.frame_id[19:17] = ACK_HAVE;
          it.frame_id[11:6]  = sb.regs.own_node;
          it.frame_id[5:0]   = sb.regs.master_node;
          it.payload         = {TAIL_MODE_UPDATE, HDR_QUERY};
          it.payload[$urandom_range(8, 63)] ^= 1'b1;
        end
        default: begin
          it.frame_id[19:17] = ACK_HAVE;
          it.frame_id[11:6]  = sb.regs.own_node;
          it.frame_id[5:0]   = sb.regs.master_node ^ 6'(1 << $urandom_range(0, 5));
          it.payload[15:0]   = {CMD_UNLOCK, HDR_CTRL};
        end
      endcase
    end
    return it;
  endfunction

  task automatic directed_checks();
    in_item_t it;
    drive_item(tick_in(12'd0, 1'b0));                                 // timer stopped
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_STATUS, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0));  // already unlocked
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_LOCK, HDR_CTRL}, 8'd255));  // speed refused
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_LOCK, HDR_CTRL}, 8'd15));
    drive_item(tick_in(12'd24, 1'b1));
    drive_item(tick_in(12'd24, 1'b1));
    drive_item(addressed(ACK_HAVE, {48'hFFFF_FFFF_FFFF, CMD_LOCK, HDR_CTRL}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_STATUS, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0));
    drive_item(tick_in(12'd0, 1'b0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_LOCK, HDR_CTRL}, 8'd0));    // restart mid-run
    drive_item(tick_in(12'd4095, 1'b0));                              // overcurrent, open
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_STATUS, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0));
    drive_item(tick_in(12'd0, 1'b1));
    drive_item(tick_in(12'd25, 1'b1));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_LOCK, HDR_CTRL}, 8'd3));
    drive_item(tick_in(12'd0, 1'b0));
    drive_item(tick_in(12'd0, 1'b0));                                 // timer stopped, switch open
    drive_item(addressed(ACK_HAVE, {TAIL_MODE_NORMAL, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {TAIL_MODE_UPDATE, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_NONE, {48'h0, CMD_VERSION, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, CMD_VERSION, HDR_QUERY}, 8'd0));
    drive_item(addressed(ACK_HAVE, {48'h0, 8'hFF, HDR_CTRL}, 8'd0));
    drive_item(addressed(ACK_RESP, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0));
    it = addressed(ACK_HAVE, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0);
    it.frame_id[5:0] = ~it.frame_id[5:0];
    drive_item(it);
    it = addressed(ACK_HAVE, {48'h0, CMD_UNLOCK, HDR_CTRL}, 8'd0);
    it.frame_id[11:6] = ~it.frame_id[11:6];
    drive_item(it);
    it = '1;
    it.func = 1'b0;
    drive_item(it);
    drive_item('0);
  endtask

  task automatic run_phase(cfg_t c, int items, int tick_pct);
    apply_setting(c);
    repeat (items) drive_item(make_traffic(tick_pct));
    end_phase();
  endtask

  initial begin : main
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting({12'd24, 8'd15, 8'd2, 6'd9, 6'd1});
    directed_checks();
    end_phase();

    run_phase({12'd24, 8'd15, 8'd20, 6'd9, 6'd1}, 150, 45);
    idle_pct = 10;
    run_phase({12'd0, 8'd0, 8'd1, 6'd0, 6'd0}, 150, 35);
    idle_pct = 40;
    run_phase({12'd4095, 8'd255, 8'd3, 6'd63, 6'd63}, 150, 50);
    idle_pct = 20;
    run_phase({12'd2000, 8'd100, 8'd0, 6'd42, 6'd17}, 350, 80);
    run_phase({12'd1, 8'd254, 8'd255, 6'd21, 6'd38}, 300, 85);
    calm     = 1'b1;
    idle_pct = 0;
    run_phase({12'd100, 8'd30, 8'd5, 6'd12, 6'd33}, 150, 40);

    $display("Ran %0d input beats across %0d register settings; %0d results checked.",
             sb.beats_in, settings, sb.checked);
    $display("Predicted %0d CAN replies and %0d finished motor runs; %0d failures.",
             sb.frames, sb.runs_done, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
